[src/mpq_pkg.sv]
// shared constants and types for the multilevel priority queue
package mpq_pkg;

  localparam int LEVELS     = 8;
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 16;

  localparam int CFG_W  = 4;
  localparam int PRIO_W = 3;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = LVL_W + PTR_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam logic [CFG_W-1:0] LEVELS_RESET = CFG_W'(8);

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

[src/mpq_in_if.sv]
// request channel of the multilevel priority queue
interface mpq_in_if
  import mpq_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [PRIO_W-1:0]     priority_req;
  logic [DATA_WIDTH-1:0] entry_data;

  modport source (output valid, output op, output priority_req, output entry_data,
                  input ready);
  modport sink   (input valid, input op, input priority_req, input entry_data,
                  output ready);
endinterface

[src/mpq_out_if.sv]
// result channel of the multilevel priority queue
interface mpq_out_if
  import mpq_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] out_data;
  logic [PRIO_W-1:0]     out_level;
  logic [1:0]            status;

  modport source (output valid, output out_data, output out_level, output status,
                  input ready);
  modport sink   (input valid, input out_data, input out_level, input status,
                  output ready);
endinterface

[src/multilevel_priority_queue.sv]
// multilevel priority queue: one ring fifo per level, lowest non-empty active level served first
// latency: the result of an item is valid in the cycle after it is accepted
// throughput: one item per cycle; the output register holds while out_ch.ready is low,
//   and a new item enters whenever the output register is empty or being taken
// reset (synchronous, rst_n low): all levels empty, pointers zero, levels_in_use = 8,
//   no result pending; the entry store itself is not cleared
module multilevel_priority_queue
  import mpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  mpq_in_if.sink           in_ch,
  mpq_out_if.source        out_ch
);

  logic [CFG_W-1:0] levels_r;

  logic [LEVELS-1:0][PTR_W-1:0] head_r, head_nxt;
  logic [LEVELS-1:0][PTR_W-1:0] tail_r, tail_nxt;
  logic [LEVELS-1:0][CNT_W-1:0] cnt_r, cnt_nxt;

  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic [PRIO_W-1:0] level_r, level_nxt;
  logic              deq_hit_r, deq_hit_nxt;

  logic [CFG_W-1:0]  act;
  logic              in_acc;
  logic              found;
  logic [LVL_W-1:0]  sel;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [LVL_W-1:0]  lvl;

  assign act    = (levels_r > CFG_W'(LEVELS)) ? CFG_W'(LEVELS) : levels_r;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign lvl    = LVL_W'(in_ch.priority_req);

  // priority encoder over the active non-empty levels
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (!found && (cnt_r[i] != '0) && (CFG_W'(i) < act)) begin
        found = 1'b1;
        sel   = LVL_W'(i);
      end
    end
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    status_nxt  = ST_OK;
    level_nxt   = '0;
    deq_hit_nxt = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = {lvl, tail_r[lvl]};
    rd_addr     = {sel, head_r[sel]};
    if (in_ch.op == OP_ENQ) begin
      if ({1'b0, in_ch.priority_req} >= (PRIO_W+1)'(act)) begin
        status_nxt = ST_RANGE;
      end else if (cnt_r[lvl] >= CNT_W'(DEPTH)) begin
        status_nxt = ST_FULL;
      end else begin
        wr_en         = in_acc;
        tail_nxt[lvl] = (tail_r[lvl] == PTR_W'(DEPTH - 1)) ? '0 : tail_r[lvl] + 1'b1;
        cnt_nxt[lvl]  = cnt_r[lvl] + 1'b1;
      end
    end else begin
      if (found) begin
        rd_en         = in_acc;
        deq_hit_nxt   = 1'b1;
        level_nxt     = PRIO_W'(sel);
        head_nxt[sel] = (head_r[sel] == PTR_W'(DEPTH - 1)) ? '0 : head_r[sel] + 1'b1;
        cnt_nxt[sel]  = cnt_r[sel] - 1'b1;
      end else begin
        status_nxt = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r    <= LEVELS_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        levels_r <= cfg_wdata;
      end
      if (in_acc) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r  <= status_nxt;
      level_r   <= level_nxt;
      deq_hit_r <= deq_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_ch.entry_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_data  = deq_hit_r ? rd_data_r : '0;
  assign out_ch.out_level = level_r;
  assign out_ch.status    = status_r;

  // a result that is not a dequeue hit carries zero data and level
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_OK || !deq_hit_r)) |->
      (out_ch.out_data == '0 && out_ch.out_level == '0))
    else $error("non-hit result with nonzero fields");

  // queue state moves only with an accepted item
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> ($stable(cnt_r) && $stable(head_r) && $stable(tail_r)))
    else $error("queue state changed without an item");

  // a dequeue hit always names an active level
  a_hit_active: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.op == OP_DEQ && found) |-> (CFG_W'(sel) < act))
    else $error("dequeue from inactive level");

  for (genvar g = 0; g < LEVELS; g++) begin : g_cnt_chk
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r[g] <= CNT_W'(DEPTH))
      else $error("level count above depth");
  end

endmodule
